// File: design/mtbd_pkg.sv
// ----------------------------------------------------------------------------
// mtbd_pkg
// Shared types and constants of the MT19937 bounded draw block.
// ----------------------------------------------------------------------------
package mtbd_pkg;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
	localparam logic [31:0] DEFAULT_SEED = 32'd4357;
	localparam logic [31:0] SEED_MULT    = 32'd69069;
	localparam int unsigned TWIST_OFFSET = 397;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_SEED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_TW_RD,
		ST_TW_WAIT,
		ST_TW_WR,
		ST_RD,
		ST_RD_WAIT,
		ST_TEMPER,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & 32'h9D2C5680);
		y = y ^ ((y << 15) & 32'hEFC60000);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage

// File: design/mersenne_twister_bounded_draw_top.sv
// Sequence: a reseed writes all STATE_WORDS state words; a draw reads one word,
// tempers it and takes its remainder in the 32-step remainder divider, after a twist
// on every STATE_WORDS-th draw (three reads with a wait each and one write per word).
// A draw with zero modulus returns zero with no memory access. One item at a time.
// Reset clears the sequencer and marks the state as never seeded; the state
// memory itself is not cleared, the first draw seeds it with 4357.
// ----------------------------------------------------------------------------
// mersenne_twister_bounded_draw_top
// MT19937 generator: reseed and bounded draw over a valid/ready interface.
// ----------------------------------------------------------------------------
module mersenne_twister_bounded_draw_top #(
	parameter int unsigned STATE_WORDS = 624
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	input  logic [31:0] modulus,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] draw_result
);
	localparam int unsigned IW = $clog2(STATE_WORDS + 2);
	localparam int unsigned AW = $clog2(STATE_WORDS);
	localparam logic [IW-1:0] IDX_FULL  = IW'(STATE_WORDS);
	localparam logic [IW-1:0] IDX_NEVER = IW'(STATE_WORDS + 1);
	localparam logic [AW-1:0] LAST      = AW'(STATE_WORDS - 1);
	localparam logic [AW-1:0] FAR_OFS   = AW'(mtbd_pkg::TWIST_OFFSET);
	localparam logic [AW-1:0] WRAP_OFS  = AW'(STATE_WORDS - mtbd_pkg::TWIST_OFFSET);

	mtbd_pkg::state_t state_q, state_d;

	// The one memory: a single port, read data registered.
	logic [31:0] mem [STATE_WORDS];
	logic [31:0] rdata_q;
	logic [AW-1:0] addr;
	logic          we;
	logic [31:0]   wdata;

	logic [IW-1:0] idx_q;
	logic [AW-1:0] k_q;       // twist word index or seed fill index
	logic [1:0]    ph_q;      // twist read phase: 0 = k, 1 = k+1, 2 = far
	logic [31:0]   cur_q, nxt_q, seed_q, mod_q, tmp_q, res_q;
	logic          opcode_q;
	logic          div_start, div_done;
	logic [31:0]   div_rem;
	logic [AW-1:0] k_next, k_far, ph_addr;
	logic [31:0]   mix_y, mix_r;

	assign k_next = (k_q == LAST) ? '0 : k_q + AW'(1);
	assign k_far  = (k_q >= WRAP_OFS) ? k_q - WRAP_OFS : k_q + FAR_OFS;
	assign ph_addr = (ph_q == 2'd0) ? k_q : (ph_q == 2'd1) ? k_next : k_far;

	// Twist of one word from the word itself, its neighbor and the far word.
	assign mix_y = {cur_q[31], nxt_q[30:0]};
	assign mix_r = rdata_q ^ (mix_y >> 1) ^ (mix_y[0] ? mtbd_pkg::TWIST_MATRIX : 32'd0);

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
	end

	mtbd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(tmp_q),
		.divisor(mod_q), .done(div_done), .remainder(div_rem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtbd_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (opcode == mtbd_pkg::OP_SEED) state_d = mtbd_pkg::ST_SEED;
					else if (modulus == 32'd0) state_d = mtbd_pkg::ST_OUT;
					else if (idx_q == IDX_NEVER) state_d = mtbd_pkg::ST_SEED;
					else if (idx_q == IDX_FULL) state_d = mtbd_pkg::ST_TW_RD;
					else state_d = mtbd_pkg::ST_RD;
				end
			end
			mtbd_pkg::ST_SEED: begin
				if (k_q == LAST) state_d = (opcode_q == mtbd_pkg::OP_SEED) ?
					mtbd_pkg::ST_IDLE : mtbd_pkg::ST_TW_RD;
			end
			mtbd_pkg::ST_TW_RD:   state_d = mtbd_pkg::ST_TW_WAIT;
			mtbd_pkg::ST_TW_WAIT: state_d = (ph_q == 2'd2) ? mtbd_pkg::ST_TW_WR :
				mtbd_pkg::ST_TW_RD;
			mtbd_pkg::ST_TW_WR:   state_d = (k_q == LAST) ? mtbd_pkg::ST_RD :
				mtbd_pkg::ST_TW_RD;
			mtbd_pkg::ST_RD:      state_d = mtbd_pkg::ST_RD_WAIT;
			mtbd_pkg::ST_RD_WAIT: state_d = mtbd_pkg::ST_TEMPER;
			mtbd_pkg::ST_TEMPER:  state_d = mtbd_pkg::ST_DIV;
			mtbd_pkg::ST_DIV:     if (div_done) state_d = mtbd_pkg::ST_OUT;
			mtbd_pkg::ST_OUT:     if (out_ready) state_d = mtbd_pkg::ST_IDLE;
			default:              state_d = mtbd_pkg::ST_IDLE;
		endcase
	end

	// Outputs and memory controls. While waiting on a twist read the address
	// is held, so the far word is still in the read register at the write.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		we        = 1'b0;
		addr      = k_q;
		wdata     = seed_q;
		div_start = 1'b0;
		unique case (state_q)
			mtbd_pkg::ST_IDLE:  in_ready = 1'b1;
			mtbd_pkg::ST_SEED:  begin we = 1'b1; wdata = seed_q; end
			mtbd_pkg::ST_TW_RD: addr = ph_addr;
			mtbd_pkg::ST_TW_WAIT: addr = ph_addr;
			mtbd_pkg::ST_TW_WR: begin we = 1'b1; wdata = mix_r; end
			mtbd_pkg::ST_RD:    addr = idx_q[AW-1:0];
			mtbd_pkg::ST_TEMPER: div_start = 1'b1;
			mtbd_pkg::ST_OUT:   out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtbd_pkg::ST_IDLE;
			idx_q   <= IDX_NEVER;
			k_q     <= '0;
			ph_q    <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				mtbd_pkg::ST_IDLE: begin
					k_q  <= '0;
					ph_q <= '0;
				end
				mtbd_pkg::ST_SEED: begin
					k_q <= (k_q == LAST) ? '0 : k_q + AW'(1);
					if (k_q == LAST) idx_q <= IDX_FULL;
				end
				mtbd_pkg::ST_TW_WAIT: ph_q <= (ph_q == 2'd2) ? 2'd0 : ph_q + 2'd1;
				mtbd_pkg::ST_TW_WR: begin
					k_q <= k_next;
					if (k_q == LAST) idx_q <= '0;
				end
				mtbd_pkg::ST_TEMPER: idx_q <= idx_q + IW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mtbd_pkg::ST_IDLE: begin
				opcode_q <= opcode;
				mod_q    <= modulus;
				seed_q   <= (opcode == mtbd_pkg::OP_SEED) ? seed_value : mtbd_pkg::DEFAULT_SEED;
				res_q    <= 32'd0;
			end
			mtbd_pkg::ST_SEED: seed_q <= seed_q * mtbd_pkg::SEED_MULT;
			mtbd_pkg::ST_TW_WAIT: begin
				if (ph_q == 2'd0) cur_q <= rdata_q;
				if (ph_q == 2'd1) nxt_q <= rdata_q;
			end
			mtbd_pkg::ST_RD_WAIT: tmp_q <= mtbd_pkg::temper(rdata_q);
			mtbd_pkg::ST_DIV:     if (div_done) res_q <= div_rem;
			default: ;
		endcase
	end

	assign draw_result = res_q;
endmodule

// File: design/mtbd_divider.sv
// ----------------------------------------------------------------------------
// mtbd_divider
// Restoring divider, one quotient bit a cycle; yields the remainder.
// ----------------------------------------------------------------------------
module mtbd_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);
	logic [31:0] rem_q, quo_q, div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (!trial[32]) rem_q <= trial[31:0];
			else            rem_q <= {rem_q[30:0], quo_q[31]};
		end
	end

	assign remainder = rem_q;
endmodule

// File: verif/mersenne_twister_bounded_draw_checker.sv
// ----------------------------------------------------------------------------
// mersenne_twister_bounded_draw_checker
// Watches both channels, predicts each draw result and compares it.
// ----------------------------------------------------------------------------
module mersenne_twister_bounded_draw_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	input  logic [31:0] modulus,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] draw_result,
	output int          fail_count,
	output int          pending_draws
);
	localparam int unsigned NWORDS = 624;

	logic [31:0] mt_words [NWORDS];
	int unsigned mt_index = NWORDS + 1;
	logic [31:0] draw_queue [$];

	assign pending_draws = draw_queue.size();

	initial fail_count = 0;

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	task automatic seed_words(input logic [31:0] s);
		mt_words[0] = s;
		for (int i = 1; i < NWORDS; i++)
			mt_words[i] = mt_words[i-1] * mtbd_pkg::SEED_MULT;
		mt_index = NWORDS;
	endtask

	task automatic twist_words();
		logic [31:0] y, r;
		for (int k = 0; k < NWORDS; k++) begin
			y = (mt_words[k] & 32'h80000000) | (mt_words[(k+1) % NWORDS] & 32'h7FFFFFFF);
			r = mt_words[(k + mtbd_pkg::TWIST_OFFSET) % NWORDS] ^ (y >> 1);
			if (y[0]) r ^= mtbd_pkg::TWIST_MATRIX;
			mt_words[k] = r;
		end
		mt_index = 0;
	endtask

	function automatic logic [31:0] tempered(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y ^= (y << 7) & 32'h9D2C5680;
		y ^= (y << 15) & 32'hEFC60000;
		y ^= y >> 18;
		return y;
	endfunction

	task automatic predict_draw(input logic [31:0] bound);
		logic [31:0] y;
		if (bound == 0) begin
			draw_queue.push_back(32'd0);
			return;
		end
		if (mt_index >= NWORDS) begin
			if (mt_index != NWORDS) seed_words(mtbd_pkg::DEFAULT_SEED);
			twist_words();
		end
		y = tempered(mt_words[mt_index]);
		mt_index++;
		draw_queue.push_back(y % bound);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (opcode == mtbd_pkg::OP_SEED) seed_words(seed_value);
				else predict_draw(modulus);
			end
			if (out_valid && out_ready) begin
				if (draw_queue.size() == 0)
					report($sformatf("unexpected result %08h", draw_result));
				else if (draw_result !== draw_queue[0]) begin
					report($sformatf("draw_result %08h, expected %08h",
						draw_result, draw_queue[0]));
					void'(draw_queue.pop_front());
				end else
					void'(draw_queue.pop_front());
			end
		end
	end
endmodule

// File: verif/mersenne_twister_bounded_draw_top_test.sv
// ----------------------------------------------------------------------------
// mersenne_twister_bounded_draw_top_test
// Drives reseed and draw items with random idling on both channels; a
// checker beside the block predicts every draw and counts mismatches.
// ----------------------------------------------------------------------------
module mersenne_twister_bounded_draw_top_test;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int RANDOM_ITEMS = 1100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = mtbd_pkg::OP_DRAW;
	logic [31:0] seed_value = '0;
	logic [31:0] modulus = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] draw_result;
	int          fail_count;
	int          pending_draws;
	int          cycle_count = 0;
	// While set, neither side idles.
	logic        steady = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	mersenne_twister_bounded_draw_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .seed_value(seed_value), .modulus(modulus),
		.out_valid(out_valid), .out_ready(out_ready), .draw_result(draw_result)
	);

	mersenne_twister_bounded_draw_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .seed_value(seed_value), .modulus(modulus),
		.out_valid(out_valid), .out_ready(out_ready), .draw_result(draw_result),
		.fail_count(fail_count), .pending_draws(pending_draws)
	);

	// The receiver stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= 35);
	end

	// The cycle counter guards against a hung block.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("mersenne_twister_bounded_draw_top test failed");
			$finish;
		end
	end

	// Presents one item and holds it until the block takes it. Before the
	// item, the sender may idle for a random number of cycles. Valid is
	// dropped only while idling, so back-to-back items keep it high.
	task automatic send_item(input logic op, input logic [31:0] s, input logic [31:0] m);
		while (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		seed_value <= s;
		modulus    <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Bounds mostly small, so residues vary, with the full range now and then.
	function automatic logic [31:0] pick_bound();
		case ($urandom_range(9))
			0: return 32'd0;
			1: return 32'hFFFFFFFF;
			2: return $urandom;
			3: return 32'd1;
			4: return 32'h80000000 | $urandom;
			default: return $urandom_range(1000, 1);
		endcase
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: a draw before any seed takes the default seed, a zero
		// bound leaves the state alone, and the extremes of both fields.
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'd0);
		send_item(mtbd_pkg::OP_DRAW, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'd1);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'd0);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'd7);
		send_item(mtbd_pkg::OP_SEED, 32'd0, 32'd0);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'hFFFFFFFF);
		send_item(mtbd_pkg::OP_SEED, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'd0);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'h80000000);
		send_item(mtbd_pkg::OP_SEED, 32'd5489, 32'd0);
		send_item(mtbd_pkg::OP_DRAW, 32'hFFFFFFFF, 32'd10);
		send_item(mtbd_pkg::OP_DRAW, 32'd0, 32'd2);

		// Random part: mostly draws, reseeds now and then. Over a thousand
		// draws, split among the reseeds, cross several twists. The items from
		// a third to a half of the way through run with no idling at all.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			steady <= (n >= RANDOM_ITEMS / 3) && (n < RANDOM_ITEMS / 2);
			if ($urandom_range(99) < 3)
				send_item(mtbd_pkg::OP_SEED, $urandom, $urandom);
			else
				send_item(mtbd_pkg::OP_DRAW, $urandom, pick_bound());
		end
		in_valid <= 1'b0;
		steady <= 1'b0;

		while (pending_draws != 0) @(posedge clk);
		repeat (2000) @(posedge clk);
		if (fail_count == 0) begin
			$display("mersenne_twister_bounded_draw_top test passed");
		end else begin
			$display("mersenne_twister_bounded_draw_top test failed");
		end
		$finish;
	end
endmodule
